// ----- hdl/aswp_pkg.sv -----
`timescale 1ns / 1ps
// aswp_pkg: types, constants and helper functions for the adaptive sample width packer
// no dependencies; used by the top level, the checker and the bench
package aswp_pkg;

    localparam int ASWP_MAX_SAMPLES = 64;
    localparam int ASWP_SAMPLE_W    = 32;
    localparam int ASWP_HEIGHT_W    = 14;
    localparam int ASWP_CFG_DATA_W  = 14;
    localparam int ASWP_CFG_IDX_W   = 1;

    localparam logic [ASWP_CFG_IDX_W-1:0] CFG_ORIGIN_MODE  = 1'd0;
    localparam logic [ASWP_CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [31:0] MASK_U8   = 32'hFFDF_C03F;
    localparam logic [31:0] MASK_U16  = 32'hFFDF_0000;
    localparam logic [31:0] MASK_I16  = 32'hFFC0_003F;
    localparam logic [31:0] MASK_BIAS = 32'h0020_0000;

    typedef enum logic [1:0] {
        ORG_TOP         = 2'd0,
        ORG_BOTTOM      = 2'd1,
        ORG_MIDDLE_DOWN = 2'd2,
        ORG_MIDDLE_UP   = 2'd3
    } t_origin;

    typedef enum logic [1:0] {
        FMT_U8_PIX  = 2'd0,
        FMT_U16_SUB = 2'd1,
        FMT_I16_PIX = 2'd2,
        FMT_FULL    = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PICK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [31:0] sample_in;
        logic               last_in;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  pack_format;
        logic [31:0] packed_value;
        logic        last_out;
    } t_out_beat;

    function automatic t_fmt pick_format(input logic [31:0] m);
        t_fmt f;
        if ((m & MASK_U8) == 32'd0) begin
            f = FMT_U8_PIX;
        end else if ((m & MASK_U16) == 32'd0) begin
            f = FMT_U16_SUB;
        end else if ((m & MASK_I16) == 32'd0) begin
            f = FMT_I16_PIX;
        end else begin
            f = FMT_FULL;
        end
        return f;
    endfunction

    function automatic logic [31:0] pack_sample(input t_fmt f, input logic [31:0] v);
        logic [31:0] p;
        case (f)
            FMT_U8_PIX:  p = {24'd0, v[13:6]};
            FMT_U16_SUB: p = {16'd0, v[15:0]};
            FMT_I16_PIX: p = {16'd0, v[21:6]};
            FMT_FULL:    p = v;
            default:     p = v;
        endcase
        return p;
    endfunction

endpackage

// ----- hdl/aswp_ram.sv -----
`timescale 1ns / 1ps
// aswp_ram: generic single-write, single-read ram with registered read data
// no dependencies
module aswp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/adaptive_sample_width_packer_top.sv -----
`timescale 1ns / 1ps
// adaptive_sample_width_packer_top: maps, stores and repacks a batch of 26.6 edge samples
// depends on aswp_pkg and aswp_ram
//
// Samples are taken one per cycle while the block is loading; each is mapped by the origin
// mode, written to the sample store and folded into a running or-mask. A beat with last_in
// set ends the batch: a pick state chooses the narrowest transfer format, then the stored
// samples leave in arrival order, one per cycle while the output side does not stall, through
// the store's read port and an output register. Input stays held off after the last beat
// until the last stored sample has been read from the store, and longer while output stalls.
// Samples beyond MAX_SAMPLES in a batch are dropped. The store needs no clearing after reset.
module adaptive_sample_width_packer_top #(
    parameter int MAX_SAMPLES = aswp_pkg::ASWP_MAX_SAMPLES
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  aswp_pkg::t_in_beat                      i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output aswp_pkg::t_out_beat                     o_out_data,
    input  logic                                    i_cfg_we,
    input  logic [aswp_pkg::ASWP_CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aswp_pkg::ASWP_CFG_DATA_W-1:0]    i_cfg_data
);
    import aswp_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    t_state r_state, n_state;

    t_origin                  r_origin;
    logic [ASWP_HEIGHT_W-1:0] r_height;

    logic [CW-1:0] r_count;
    logic [31:0]   r_mask;
    t_fmt          r_fmt;
    logic [CW-1:0] r_idx;

    logic      r_pend;
    logic      r_pend_last;
    t_fmt      r_pend_fmt;
    logic      r_out_valid;
    t_out_beat r_out;

    logic        in_acc;
    logic        store_ok;
    logic        neg;
    logic [31:0] offset;
    logic [31:0] mapped;
    logic        issue;
    logic        issue_last;
    logic        move;
    logic [31:0] rdata;

    assign in_acc   = i_in_valid && o_in_ready;
    assign store_ok = (r_count < CW'(MAX_SAMPLES));

    // negate for bottom and middle up, offset is height in 1/64 or half of it
    always_comb begin
        neg    = (r_origin == ORG_BOTTOM) || (r_origin == ORG_MIDDLE_UP);
        offset = 32'd0;
        case (r_origin)
            ORG_TOP:         offset = 32'd0;
            ORG_BOTTOM:      offset = {12'd0, r_height, 6'd0};
            ORG_MIDDLE_DOWN: offset = {13'd0, r_height, 5'd0};
            ORG_MIDDLE_UP:   offset = {13'd0, r_height, 5'd0};
            default:         offset = 32'd0;
        endcase
        mapped = (neg ? ~i_in_data.sample_in : i_in_data.sample_in) + offset + {31'd0, neg};
    end

    // move the read word into the output register once it is free
    assign move       = r_pend && (!r_out_valid || i_out_ready);
    assign issue_last = ((r_idx + CW'(1)) == r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_in_data.last_in) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: n_state = ST_EMIT;
            ST_EMIT: begin
                if (issue && issue_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        issue      = 1'b0;
        case (r_state)
            ST_LOAD: o_in_ready = 1'b1;
            ST_PICK: o_in_ready = 1'b0;
            ST_EMIT: issue = (r_idx < r_count) && (!r_pend || move);
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= ORG_TOP;
            r_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_MODE:  r_origin <= t_origin'(i_cfg_data[1:0]);
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[ASWP_HEIGHT_W-1:0];
                default:          r_origin <= r_origin;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mask  <= '0;
            r_fmt   <= FMT_U8_PIX;
            r_idx   <= '0;
        end else begin
            if (in_acc && store_ok) begin
                r_count <= r_count + CW'(1);
                r_mask  <= r_mask | (mapped + MASK_BIAS);
            end
            if (r_state == ST_PICK) begin
                r_fmt  <= pick_format(r_mask);
                r_mask <= '0;
                r_idx  <= '0;
            end
            if (issue) begin
                r_idx <= r_idx + CW'(1);
                if (issue_last) begin
                    r_count <= '0;
                end
            end
        end
    end

    // reads and writes never overlap: writes only while loading, reads only while emitting
    aswp_ram #(
        .WIDTH (ASWP_SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (mapped),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (issue) begin
            r_pend <= 1'b1;
        end else if (move) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last <= issue_last;
            r_pend_fmt  <= r_fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.pack_format  <= r_pend_fmt;
            r_out.packed_value <= pack_sample(r_pend_fmt, rdata);
            r_out.last_out     <= r_pend_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/aswp_chk.sv -----
`timescale 1ns / 1ps
// aswp_chk: port-level checks for the adaptive sample width packer, bound to the top level
// depends on aswp_pkg
module aswp_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input aswp_pkg::t_in_beat                   i_in_data,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input aswp_pkg::t_out_beat                  o_out_data,
    input logic                                 i_cfg_we,
    input logic [aswp_pkg::ASWP_CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [aswp_pkg::ASWP_CFG_DATA_W-1:0] i_cfg_data
);
    import aswp_pkg::*;

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // a last beat closes the input until the batch has been read out
    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_in) |=> !o_in_ready)
        else $error("input still open after last beat");

    // inside a batch the next packed beat is ready straight away
    a_batch_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_out_data.last_out) |=> o_out_valid)
        else $error("gap inside an output batch");

    // one format for the whole batch
    a_batch_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_out_data.last_out) |=> $stable(o_out_data.pack_format))
        else $error("format changed inside a batch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output beat dropped or changed while stalled");

endmodule

bind adaptive_sample_width_packer_top aswp_chk u_aswp_chk (.*);

// ----- verif/adaptive_sample_width_packer_top_tb.sv -----
`timescale 1ns / 1ps
// adaptive_sample_width_packer_top_tb: self-checking bench for the adaptive sample width packer
// depends on aswp_pkg and adaptive_sample_width_packer_top; predicts every packed beat from the
// accepted edge samples and checks the output stream in order under random stalls
module adaptive_sample_width_packer_top_tb;
    import aswp_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int PRINT_CAP     = 30;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    t_in_beat                   in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_out_beat                  out_data;
    logic                       cfg_we    = 1'b0;
    logic [ASWP_CFG_IDX_W-1:0]  cfg_idx   = CFG_ORIGIN_MODE;
    logic [ASWP_CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state, follows the block's registers and sample store
    t_origin     cur_origin = ORG_TOP;
    logic [13:0] cur_height = '0;
    logic [31:0] edge_store [0:ASWP_MAX_SAMPLES-1];
    logic [31:0] fold_mask  = '0;
    int          held       = 0;

    t_out_beat   due_beats [$];
    t_in_beat    pending_edges [$];

    // stimulus view of the configuration about to be used
    t_origin     stim_origin = ORG_TOP;
    logic [13:0] stim_height = '0;

    int send_idle = 0;
    int recv_idle = 0;

    int n_edges    = 0;
    int n_dropped  = 0;
    int n_batches  = 0;
    int n_checked  = 0;
    int n_faults   = 0;
    int fmt_seen [4] = '{0, 0, 0, 0};

    adaptive_sample_width_packer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] origin_offset(input t_origin m, input logic [13:0] h);
        logic [31:0] off;
        case (m)
            ORG_BOTTOM:                     off = {12'd0, h, 6'd0};
            ORG_MIDDLE_DOWN, ORG_MIDDLE_UP: off = {13'd0, h, 5'd0};
            default:                        off = 32'd0;
        endcase
        return off;
    endfunction

    function automatic logic flips(input t_origin m);
        return (m == ORG_BOTTOM) || (m == ORG_MIDDLE_UP);
    endfunction

    function automatic t_fmt narrowest_format(input logic [31:0] m);
        t_fmt f;
        f = FMT_FULL;
        if ((m & MASK_I16) == 32'd0) f = FMT_I16_PIX;
        if ((m & MASK_U16) == 32'd0) f = FMT_U16_SUB;
        if ((m & MASK_U8) == 32'd0)  f = FMT_U8_PIX;
        return f;
    endfunction

    function automatic logic [31:0] pack_edge(input t_fmt f, input logic [31:0] v);
        logic [31:0] p;
        case (f)
            FMT_U8_PIX:  p = (v >> 6) & 32'h0000_00FF;
            FMT_U16_SUB: p = v & 32'h0000_FFFF;
            FMT_I16_PIX: p = (v >> 6) & 32'h0000_FFFF;
            default:     p = v;
        endcase
        return p;
    endfunction

    // one accepted beat: map, store, fold into the mask; a last beat releases the batch
    task automatic absorb_edge(input t_in_beat b);
        logic [31:0] s;
        logic [31:0] v;
        t_fmt        f;
        t_out_beat   w;
        n_edges++;
        if (held < ASWP_MAX_SAMPLES) begin
            s = b.sample_in;
            v = (flips(cur_origin) ? (32'd0 - s) : s) + origin_offset(cur_origin, cur_height);
            edge_store[held] = v;
            held++;
            fold_mask = fold_mask | (v + MASK_BIAS);
        end else begin
            n_dropped++;
        end
        if (b.last_in) begin
            f = narrowest_format(fold_mask);
            for (int i = 0; i < held; i++) begin
                w.pack_format  = f;
                w.packed_value = pack_edge(f, edge_store[i]);
                w.last_out     = (i == held - 1);
                due_beats.push_back(w);
            end
            fmt_seen[int'(f)]++;
            n_batches++;
            held      = 0;
            fold_mask = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_faults < PRINT_CAP)
            $display("%0t ns mismatch: %s got %h want %h", $time, what, got, want);
        n_faults++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            cur_origin <= ORG_TOP;
            cur_height <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_ORIGIN_MODE:  cur_origin <= t_origin'(cfg_data[1:0]);
                CFG_FRAME_HEIGHT: cur_height <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // sender: valid holds until the beat is taken, then the next beat may follow at once
    always @(posedge clk) begin : drive_edges
        logic go;
        if (!rst_n) begin
            held      = 0;
            fold_mask = '0;
            in_valid <= 1'b0;
        end else begin
            go = in_valid;
            if (in_valid && in_ready) begin
                absorb_edge(in_data);
                go = 1'b0;
            end
            if (!go && pending_edges.size() > 0 && $urandom_range(99) >= send_idle) begin
                in_data <= pending_edges.pop_front();
                go = 1'b1;
            end
            in_valid <= go;
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin : check_beats
        t_out_beat w;
        if (rst_n && out_valid && out_ready) begin
            if (due_beats.size() == 0) begin
                report_mismatch("beat with nothing due", out_data.packed_value, 32'd0);
            end else begin
                w = due_beats.pop_front();
                n_checked++;
                if (out_data.pack_format !== w.pack_format)
                    report_mismatch("pack_format", 32'(out_data.pack_format),
                                    32'(w.pack_format));
                if (out_data.packed_value !== w.packed_value)
                    report_mismatch("packed_value", out_data.packed_value, w.packed_value);
                if (out_data.last_out !== w.last_out)
                    report_mismatch("last_out", 32'(out_data.last_out), 32'(w.last_out));
            end
        end
    end

    task automatic queue_edge(input logic [31:0] s, input logic last);
        t_in_beat b;
        b.sample_in = s;
        b.last_in   = last;
        pending_edges.push_back(b);
    endtask

    task automatic write_reg(input logic [ASWP_CFG_IDX_W-1:0] idx,
                             input logic [ASWP_CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // upper bits of the mode write carry junk the block must ignore
    task automatic set_origin(input t_origin m, input logic [13:0] h);
        write_reg(CFG_ORIGIN_MODE, {12'($urandom), m});
        write_reg(CFG_FRAME_HEIGHT, h);
        stim_origin = m;
        stim_height = h;
        @(negedge clk);
    endtask

    // input sample that maps onto the wanted value under the pending configuration
    function automatic logic [31:0] edge_for(input logic [31:0] t);
        logic [31:0] s;
        s = t - origin_offset(stim_origin, stim_height);
        return flips(stim_origin) ? (32'd0 - s) : s;
    endfunction

    function automatic logic [31:0] target_of(input t_fmt f);
        logic [31:0] t;
        logic [15:0] r;
        r = 16'($urandom);
        case (f)
            FMT_U8_PIX:  t = {18'd0, r[7:0], 6'd0};
            FMT_U16_SUB: t = {16'd0, r};
            FMT_I16_PIX: t = {{10{r[15]}}, r, 6'd0};
            default:     t = $urandom;
        endcase
        return t;
    endfunction

    task automatic queue_batch(input int len);
        logic        mixed;
        t_fmt        f;
        logic [31:0] s;
        mixed = ($urandom_range(4) == 0);
        f     = t_fmt'($urandom_range(3));
        for (int i = 0; i < len; i++) begin
            if (mixed)
                f = t_fmt'($urandom_range(3));
            if ($urandom_range(9) == 0)
                s = $urandom;
            else
                s = edge_for(target_of(f));
            queue_edge(s, i == len - 1);
        end
    endtask

    task automatic wait_idle;
        while (pending_edges.size() != 0 || in_valid || due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_segment(input int seg, input logic overfill);
        logic [13:0] h;
        int          queued;
        int          len;
        int          r;
        case (seg % 3)
            0:       h = 14'd0;
            1:       h = 14'h3FFF;
            default: h = 14'($urandom);
        endcase
        set_origin(t_origin'(seg % 4), h);
        queued = 0;
        if (overfill) begin
            len = $urandom_range(ASWP_MAX_SAMPLES + 8, ASWP_MAX_SAMPLES + 1);
            queue_batch(len);
            queued += len;
        end
        while (queued < 8) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(8, 1);
            else if (r < 98)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(ASWP_MAX_SAMPLES + 8, ASWP_MAX_SAMPLES + 1);
            queue_batch(len);
            queued += len;
        end
        wait_idle;
    endtask

    initial begin
        send_idle = 37;
        recv_idle = 81;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_origin(ORG_TOP, 14'd0);
        // whole-pixel bytes
        queue_edge(32'h0000_0000, 1'b0);
        queue_edge(32'h0000_3FC0, 1'b1);
        // 16-bit sub-pixel
        queue_edge(32'h0000_FFFF, 1'b0);
        queue_edge(32'h0000_0001, 1'b1);
        // signed pixel range ends
        queue_edge(32'hFFE0_0000, 1'b0);
        queue_edge(32'h001F_FFC0, 1'b1);
        // full width extremes
        queue_edge(32'h7FFF_FFFF, 1'b0);
        queue_edge(32'h8000_0000, 1'b0);
        queue_edge(32'hFFFF_FFFF, 1'b1);
        // batch of one beat
        queue_edge(32'h0000_0040, 1'b1);
        wait_idle;
        for (int m = ORG_BOTTOM; m <= ORG_MIDDLE_UP; m++) begin
            set_origin(t_origin'(m), 14'h3FFF);
            queue_edge(edge_for(32'h0000_0140), 1'b0);
            queue_edge(32'h7FFF_FFFF, 1'b0);
            queue_edge(32'h8000_0000, 1'b1);
            wait_idle;
        end

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 37;
                    recv_idle = 81;
                end
                1: begin
                    send_idle = 81;
                    recv_idle = 37;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < 4; s++)
                run_segment(p * 4 + s, (p == 0) && (s == 1));
        end

        wait_idle;
        if (due_beats.size() != 0)
            report_mismatch("beats never delivered", 32'(due_beats.size()), 32'd0);
        $display("covered %0d edge samples in %0d batches, %0d dropped on a full store,",
                 n_edges, n_batches, n_dropped);
        $display("%0d beats checked; formats: u8 %0d, u16 %0d, i16 %0d, full %0d; %0d mismatches",
                 n_checked, fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3], n_faults);
        if (n_faults == 0)
            $display("adaptive_sample_width_packer_top regression: pass");
        else
            $display("adaptive_sample_width_packer_top regression: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d beats still due", due_beats.size());
        $display("adaptive_sample_width_packer_top regression: fail");
        $finish;
    end

endmodule
